// ----- rtl/core/ctlp_pkg.sv -----
// Shared types and constants for the CD table-of-contents track list parser.
package ctlp_pkg;

   localparam int unsigned DESCRIPTOR_CAP = 100;
   localparam int unsigned CSR_ADDR_W      = 3;
   localparam int unsigned FIFO_DEPTH      = 4;
   localparam int unsigned FIFO_PTR_W      = $clog2(FIFO_DEPTH);
   localparam int unsigned FIFO_CNT_W      = $clog2(FIFO_DEPTH + 1);

   localparam logic [7:0] LEAD_OUT          = 8'hAA;
   localparam int unsigned DATA_BIT         = 2;
   localparam logic [9:0] POS_MAX           = 10'd1023;
   localparam logic [6:0] TRACK_LIMIT_RESET = 7'd99;
   localparam logic [6:0] MAX_DESC_CODE     = 7'(DESCRIPTOR_CAP);

   // Header byte positions.
   localparam logic [9:0] POS_LEN_HI     = 10'd0;
   localparam logic [9:0] POS_LEN_LO     = 10'd1;
   localparam logic [9:0] POS_FIRST      = 10'd2;
   localparam logic [9:0] POS_LAST       = 10'd3;
   localparam logic [9:0] POS_DESC_START = 10'd4;

   // Byte offsets inside an 8-byte descriptor.
   localparam logic [2:0] OFF_CONTROL    = 3'd1;
   localparam logic [2:0] OFF_NUMBER     = 3'd2;
   localparam logic [2:0] OFF_ADDR_FIRST = 3'd4;
   localparam logic [2:0] OFF_ADDR_LAST  = 3'd7;

   // Register index of the configuration port.
   localparam logic REG_TRACK_LIMIT = 1'b0;

   typedef struct packed {
      logic [7:0] toc_byte;
      logic       end_of_response;
   } ctlp_req_type;

   typedef struct packed {
      logic        has_track;
      logic [7:0]  track_number;
      logic        audio_track;
      logic [31:0] start_block;
      logic [31:0] end_block;
      logic [6:0]  tracks_so_far;
      logic        final_result;
   } ctlp_rsp_type;

   // Which of the two result slots the parser fills in one cycle.
   typedef struct packed {
      logic track_valid;
      logic final_valid;
   } ctlp_push_type;

endpackage

// ----- rtl/core/ctlp_parser.sv -----
// Byte parser: header and descriptor capture, track acceptance and result forming.
module ctlp_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  go,
   input  ctlp_pkg::ctlp_req_type item,
   input  logic [6:0]            track_limit,
   output ctlp_pkg::ctlp_push_type push,
   output ctlp_pkg::ctlp_rsp_type  track_rsp,
   output ctlp_pkg::ctlp_rsp_type  final_rsp
);
   import ctlp_pkg::*;

   logic [9:0]  pos_ff, pos_in;
   logic [15:0] len_ff, len_in;
   logic [7:0]  lo_ff, lo_in;
   logic [7:0]  hi_ff, hi_in;
   logic [3:0]  ctl_ff, ctl_in;
   logic [7:0]  num_ff, num_in;
   logic [31:0] addr_ff, addr_in;
   logic        pend_valid_ff, pend_valid_in;
   logic [7:0]  pend_num_ff, pend_num_in;
   logic        pend_audio_ff, pend_audio_in;
   logic [31:0] pend_start_ff, pend_start_in;
   logic [31:0] pend_end_ff, pend_end_in;
   logic [6:0]  count_ff, count_in;

   logic [9:0]  rel;
   logic [6:0]  idx;
   logic [2:0]  off;
   logic [15:0] avail;
   logic [12:0] desc_limit;
   logic [31:0] addr_shift;
   logic        desc_done;
   logic        emit_track;

   assign rel        = pos_ff - POS_DESC_START;
   assign idx        = rel[9:3];
   assign off        = rel[2:0];
   assign avail      = (len_ff > 16'd2) ? (len_ff - 16'd2) : 16'd0;
   assign desc_limit = avail[15:3];
   assign addr_shift = {addr_ff[23:0], item.toc_byte};
   assign desc_done  = (pos_ff >= POS_DESC_START) && (off == OFF_ADDR_LAST)
                       && ({6'd0, idx} < desc_limit) && (idx < MAX_DESC_CODE)
                       && (count_ff < track_limit);

   always_comb begin
      pos_in        = (pos_ff < POS_MAX) ? pos_ff + 10'd1 : pos_ff;
      len_in        = len_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      ctl_in        = ctl_ff;
      num_in        = num_ff;
      addr_in       = addr_ff;
      pend_valid_in = pend_valid_ff;
      pend_num_in   = pend_num_ff;
      pend_audio_in = pend_audio_ff;
      pend_start_in = pend_start_ff;
      pend_end_in   = pend_end_ff;
      count_in      = count_ff;
      emit_track    = 1'b0;

      case (pos_ff)
         POS_LEN_HI: len_in = {item.toc_byte, 8'd0};
         POS_LEN_LO: len_in = {len_ff[15:8], item.toc_byte};
         POS_FIRST:  lo_in  = item.toc_byte;
         POS_LAST:   hi_in  = item.toc_byte;
         default: begin
            if (off == OFF_CONTROL) begin
               ctl_in = item.toc_byte[3:0];
            end else if (off == OFF_NUMBER) begin
               num_in = item.toc_byte;
            end else if (off >= OFF_ADDR_FIRST) begin
               addr_in = addr_shift;
            end
         end
      endcase

      if (desc_done) begin
         if (num_ff == LEAD_OUT) begin
            if (pend_valid_ff) begin
               pend_end_in = addr_shift;
            end
         end else if ((num_ff >= lo_ff) && (num_ff <= hi_ff)) begin
            count_in      = count_ff + 7'd1;
            emit_track    = pend_valid_ff;
            pend_valid_in = 1'b1;
            pend_num_in   = num_ff;
            pend_audio_in = ~ctl_ff[DATA_BIT];
            pend_start_in = addr_shift;
            pend_end_in   = addr_shift;
         end
      end
   end

   always_comb begin
      track_rsp.has_track     = 1'b1;
      track_rsp.track_number  = pend_num_ff;
      track_rsp.audio_track   = pend_audio_ff;
      track_rsp.start_block   = pend_start_ff;
      track_rsp.end_block     = addr_shift;
      track_rsp.tracks_so_far = count_in;
      track_rsp.final_result  = 1'b0;

      // The closing result reports the pending track as it stands after this byte.
      final_rsp.has_track     = pend_valid_in;
      final_rsp.track_number  = pend_valid_in ? pend_num_in : 8'd0;
      final_rsp.audio_track   = pend_valid_in & pend_audio_in;
      final_rsp.start_block   = pend_valid_in ? pend_start_in : 32'd0;
      final_rsp.end_block     = pend_valid_in ? pend_end_in : 32'd0;
      final_rsp.tracks_so_far = count_in;
      final_rsp.final_result  = 1'b1;

      push.track_valid = go & emit_track;
      push.final_valid = go & item.end_of_response;
   end

   always_ff @(posedge clock) begin
      if (reset || (go && item.end_of_response)) begin
         pos_ff        <= '0;
         len_ff        <= '0;
         lo_ff         <= '0;
         hi_ff         <= '0;
         ctl_ff        <= '0;
         num_ff        <= '0;
         addr_ff       <= '0;
         pend_valid_ff <= 1'b0;
         pend_num_ff   <= '0;
         pend_audio_ff <= 1'b0;
         pend_start_ff <= '0;
         pend_end_ff   <= '0;
         count_ff      <= '0;
      end else if (go) begin
         pos_ff        <= pos_in;
         len_ff        <= len_in;
         lo_ff         <= lo_in;
         hi_ff         <= hi_in;
         ctl_ff        <= ctl_in;
         num_ff        <= num_in;
         addr_ff       <= addr_in;
         pend_valid_ff <= pend_valid_in;
         pend_num_ff   <= pend_num_in;
         pend_audio_ff <= pend_audio_in;
         pend_start_ff <= pend_start_in;
         pend_end_ff   <= pend_end_in;
         count_ff      <= count_in;
      end
   end

endmodule

// ----- rtl/core/ctlp_rsp_fifo.sv -----
// Result queue that takes up to two results per cycle and hands out one.
module ctlp_rsp_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  ctlp_pkg::ctlp_push_type push,
   input  ctlp_pkg::ctlp_rsp_type  track_rsp,
   input  ctlp_pkg::ctlp_rsp_type  final_rsp,
   output logic                   room,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output ctlp_pkg::ctlp_rsp_type  rsp_data
);
   import ctlp_pkg::*;

   ctlp_rsp_type                 mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]        cnt_ff, cnt_in;
   logic [FIFO_PTR_W-1:0]        wr_next;
   logic [FIFO_CNT_W-1:0]        n_push;
   logic                         pop;
   ctlp_rsp_type                 first_rsp;

   assign pop       = rsp_valid & rsp_ready;
   assign rsp_valid = (cnt_ff != '0);
   assign rsp_data  = mem_ff[rd_ptr_ff];
   // Two free entries are needed before the parser may take another byte.
   assign room      = (cnt_ff <= FIFO_CNT_W'(FIFO_DEPTH - 2));
   assign wr_next   = wr_ptr_ff + FIFO_PTR_W'(1);
   assign first_rsp = push.track_valid ? track_rsp : final_rsp;
   assign n_push    = FIFO_CNT_W'(push.track_valid) + FIFO_CNT_W'(push.final_valid);
   assign wr_ptr_in = wr_ptr_ff + n_push[FIFO_PTR_W-1:0];
   assign rd_ptr_in = rd_ptr_ff + FIFO_PTR_W'(pop);
   assign cnt_in    = cnt_ff + n_push - FIFO_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (push.track_valid || push.final_valid) begin
         mem_ff[wr_ptr_ff] <= first_rsp;
      end
      if (push.track_valid && push.final_valid) begin
         mem_ff[wr_next] <= final_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

// ----- rtl/core/cd_toc_track_list_parser.sv -----
// Top level: input register, register port, parser and result queue.
// A byte waits in the input register for queue room; its results then enter the queue.
// Throughput: one byte per cycle while the result queue has two free entries; a byte that
// yields two results (a track and the closing result) queues both at once.
// Reset is synchronous and active high; it empties the queue, clears the parse state and
// sets track_limit to 99. The parse state also returns to zero after each closing result.
module cd_toc_track_list_parser (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  ctlp_pkg::ctlp_req_type        req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output ctlp_pkg::ctlp_rsp_type        rsp_data,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [ctlp_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);
   import ctlp_pkg::*;

   logic         in_valid_ff, in_valid_in;
   ctlp_req_type in_data_ff;
   logic [6:0]   limit_ff;
   logic         room;
   logic         go;
   logic         reg_sel;
   ctlp_push_type push;
   ctlp_rsp_type  track_rsp;
   ctlp_rsp_type  final_rsp;

   assign csr_pready = 1'b1;
   assign reg_sel    = (csr_paddr[CSR_ADDR_W-1] == REG_TRACK_LIMIT);
   assign csr_prdata = reg_sel ? {25'd0, limit_ff} : 32'd0;

   assign go          = in_valid_ff & room;
   assign req_ready   = ~in_valid_ff | room;
   assign in_valid_in = (req_valid & req_ready) | (in_valid_ff & ~go);

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= TRACK_LIMIT_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && reg_sel) begin
         limit_ff <= csr_pwdata[6:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
   end

   ctlp_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .go          (go),
      .item        (in_data_ff),
      .track_limit (limit_ff),
      .push        (push),
      .track_rsp   (track_rsp),
      .final_rsp   (final_rsp)
   );

   ctlp_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .track_rsp (track_rsp),
      .final_rsp (final_rsp),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- rtl/core/ctlp_checker.sv -----
// Port-level checks for the track list parser and their attachment to the top level.
module ctlp_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input ctlp_pkg::ctlp_rsp_type rsp_data
);
   import ctlp_pkg::*;

   // A waiting result keeps its value until its transfer.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // A result without a track can only be the closing summary, with empty fields.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.has_track |-> rsp_data.final_result
         && rsp_data.track_number == 8'd0 && rsp_data.start_block == 32'd0
         && rsp_data.end_block == 32'd0 && !rsp_data.audio_track)
      else $error("empty result is not a clean closing summary");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.has_track |-> rsp_data.tracks_so_far != 7'd0)
      else $error("track result with zero track count");

endmodule

bind cd_toc_track_list_parser ctlp_checker u_ctlp_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ----- bench/cd_toc_track_list_parser_test.sv -----
// Self-checking testbench for the CD table-of-contents track list parser.
`timescale 1ns / 100ps

module cd_toc_track_list_parser_test;
   import ctlp_pkg::*;

   localparam int CYCLE_LIMIT  = 400_000;
   localparam int DRAIN_CYCLES = 8;
   localparam logic [CSR_ADDR_W-1:0] LIMIT_ADDR = CSR_ADDR_W'(4 * REG_TRACK_LIMIT);
   localparam logic [CSR_ADDR_W-1:0] SPARE_ADDR = LIMIT_ADDR + CSR_ADDR_W'(4);

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   ctlp_req_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   ctlp_rsp_type rsp_data;
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   cd_toc_track_list_parser dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Parser state as the block should hold it.
   logic [9:0]  pos_count;
   logic [15:0] length_field;
   logic [7:0]  low_track_no, high_track_no;
   logic [3:0]  desc_control;
   logic [7:0]  desc_number;
   logic [31:0] desc_lba;
   logic        held_valid;
   logic [7:0]  held_number;
   logic        held_audio;
   logic [31:0] held_start, held_end;
   logic [6:0]  tracks_taken;
   logic [6:0]  limit_setting = TRACK_LIMIT_RESET;

   ctlp_rsp_type track_entries_due[$];
   logic [7:0]   toc_image[$];

   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int hold_off_cycles = 0;
   int bytes_sent = 0;
   int responses_sent = 0;
   int entries_checked = 0;
   int mismatch_count = 0;

   function automatic void clear_parse_state();
      pos_count = '0;
      length_field = '0;
      low_track_no = '0;
      high_track_no = '0;
      desc_control = '0;
      desc_number = '0;
      desc_lba = '0;
      held_valid = 1'b0;
      held_number = '0;
      held_audio = 1'b0;
      held_start = '0;
      held_end = '0;
      tracks_taken = '0;
   endfunction

   initial clear_parse_state();

   function automatic void queue_entry(logic has, logic fin);
      ctlp_rsp_type e;
      e.has_track     = has;
      e.track_number  = has ? held_number : 8'd0;
      e.audio_track   = has ? held_audio : 1'b0;
      e.start_block   = has ? held_start : 32'd0;
      e.end_block     = has ? held_end : 32'd0;
      e.tracks_so_far = tracks_taken;
      e.final_result  = fin;
      track_entries_due.push_back(e);
   endfunction

   // Advances the parser state by one transferred byte and queues what it emits.
   function automatic void parse_toc_byte(logic [7:0] b, logic last);
      logic [9:0] rel;
      logic [2:0] off;
      int         idx;
      int         avail;
      if (pos_count == POS_LEN_HI) begin
         length_field = {b, 8'h00};
      end else if (pos_count == POS_LEN_LO) begin
         length_field[7:0] = b;
      end else if (pos_count == POS_FIRST) begin
         low_track_no = b;
      end else if (pos_count == POS_LAST) begin
         high_track_no = b;
      end else begin
         rel = pos_count - POS_DESC_START;
         off = rel[2:0];
         idx = int'(rel[9:3]);
         if (off == OFF_CONTROL) begin
            desc_control = b[3:0];
         end else if (off == OFF_NUMBER) begin
            desc_number = b;
         end else if (off >= OFF_ADDR_FIRST) begin
            desc_lba = {desc_lba[23:0], b};
         end
         if (off == OFF_ADDR_LAST) begin
            avail = (length_field > 16'd2) ? int'(length_field) - 2 : 0;
            if (idx < avail / 8 && idx < DESCRIPTOR_CAP && tracks_taken < limit_setting) begin
               if (desc_number == LEAD_OUT) begin
                  if (held_valid) held_end = desc_lba;
               end else if (desc_number >= low_track_no && desc_number <= high_track_no) begin
                  tracks_taken = tracks_taken + 7'd1;
                  if (held_valid) begin
                     held_end = desc_lba;
                     queue_entry(1'b1, 1'b0);
                  end
                  held_valid = 1'b1;
                  held_number = desc_number;
                  held_audio = ~desc_control[DATA_BIT];
                  held_start = desc_lba;
                  held_end = desc_lba;
               end
            end
         end
      end
      if (pos_count < POS_MAX) pos_count = pos_count + 10'd1;
      if (last) begin
         queue_entry(held_valid, 1'b1);
         clear_parse_state();
      end
   endfunction

   function automatic string entry_text(ctlp_rsp_type e);
      return $sformatf("has=%0d track=%0d audio=%0d start=%h end=%h count=%0d final=%0d",
                       e.has_track, e.track_number, e.audio_track, e.start_block,
                       e.end_block, e.tracks_so_far, e.final_result);
   endfunction

   task automatic check_track_entry(input ctlp_rsp_type got);
      ctlp_rsp_type want;
      entries_checked++;
      if (track_entries_due.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10) $display("Result with nothing due: %s", entry_text(got));
      end else begin
         want = track_entries_due.pop_front();
         if (got.has_track !== want.has_track || got.track_number !== want.track_number ||
             got.audio_track !== want.audio_track || got.start_block !== want.start_block ||
             got.end_block !== want.end_block || got.tracks_so_far !== want.tracks_so_far ||
             got.final_result !== want.final_result) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("Mismatch on result %0d", entries_checked);
               $display("   expected %s", entry_text(want));
               $display("   actual   %s", entry_text(got));
            end
         end
      end
   endtask

   // Result side: checks each transfer, then picks ready for the next cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) check_track_entry(rsp_data);
      if (hold_off_cycles > 0) begin
         hold_off_cycles--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Timed out after %0d cycles", CYCLE_LIMIT);
      $display("end of test: mismatches");
      $finish;
   end

   task automatic set_idling(input int sender_pct, input int receiver_pct);
      sender_idle_pct = sender_pct;
      receiver_stall_pct = receiver_pct;
   endtask

   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{toc_byte: b, end_of_response: last};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      parse_toc_byte(b, last);
      bytes_sent++;
      if (last) responses_sent++;
   endtask

   task automatic play_toc();
      foreach (toc_image[i]) send_byte(toc_image[i], i == toc_image.size() - 1);
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (track_entries_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_ADDR_W-1:0] addr, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr == LIMIT_ADDR) limit_setting = value[6:0];
   endtask

   // Upper bits are random; only the low seven hold the limit.
   task automatic write_track_limit(input logic [6:0] value);
      logic [31:0] word;
      word = $urandom;
      word[6:0] = value;
      write_csr(LIMIT_ADDR, word);
   endtask

   function automatic void add_header(logic [15:0] len, logic [7:0] first, logic [7:0] last);
      toc_image.push_back(len[15:8]);
      toc_image.push_back(len[7:0]);
      toc_image.push_back(first);
      toc_image.push_back(last);
   endfunction

   function automatic void add_descriptor(logic [7:0] control, logic [7:0] num,
                                          logic [31:0] lba);
      toc_image.push_back(8'($urandom));
      toc_image.push_back(control);
      toc_image.push_back(num);
      toc_image.push_back(8'($urandom));
      toc_image.push_back(lba[31:24]);
      toc_image.push_back(lba[23:16]);
      toc_image.push_back(lba[15:8]);
      toc_image.push_back(lba[7:0]);
   endfunction

   // Mostly well-formed responses; a broken one has a bad header and is cut or runs long.
   task automatic build_toc(input bit broken);
      int          n_tracks, n_desc, first_no, last_no, len_field, cut;
      logic [31:0] lba;
      logic [7:0]  num;
      toc_image.delete();
      n_tracks = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 6);
      n_desc = n_tracks + (($urandom_range(0, 4) != 0) ? 1 : 0);
      first_no = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 9);
      last_no = first_no + ((n_tracks > 0) ? n_tracks - 1 : 0);
      if (last_no > 255) last_no = 255;
      len_field = 2 + 8 * n_desc;
      if (broken) begin
         case ($urandom_range(0, 3))
            0: len_field = $urandom_range(0, 16'hFFFF);
            1: len_field = $urandom_range(0, 2);
            2: begin
               len_field = len_field - 8 * $urandom_range(1, n_desc + 1);
               if (len_field < 0) len_field = 0;
            end
            default: last_no = $urandom_range(0, 255);
         endcase
      end
      add_header(16'(len_field), 8'(first_no), 8'(last_no));
      lba = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 300);
      for (int i = 0; i < n_desc; i++) begin
         if (i == n_tracks) num = LEAD_OUT;
         else if ($urandom_range(0, 7) == 0) num = 8'($urandom);
         else num = 8'(first_no + i);
         lba = lba + $urandom_range(1, 40000);
         add_descriptor(8'($urandom), num, lba);
      end
      if (broken) begin
         if ($urandom_range(0, 1) == 1) begin
            cut = $urandom_range(1, toc_image.size());
            while (toc_image.size() > cut) void'(toc_image.pop_back());
         end else begin
            repeat ($urandom_range(1, 12)) toc_image.push_back(8'($urandom));
         end
      end
   endtask

   task automatic run_responses(input int byte_budget);
      int start_bytes;
      start_bytes = bytes_sent;
      while (bytes_sent - start_bytes < byte_budget) begin
         build_toc($urandom_range(0, 4) == 0);
         play_toc();
      end
   endtask

   // A response that ends on its first byte closes with an empty summary.
   task automatic test_empty_summary();
      send_byte(8'hFF, 1'b1);
      wait_drain();
   endtask

   // Track numbers 0 and 255, all-ones and all-zero addresses, both control nibbles.
   task automatic test_field_extremes();
      toc_image.delete();
      add_header(16'd26, 8'h00, 8'hFF);
      add_descriptor(8'hFF, 8'h00, 32'hFFFF_FFFF);
      add_descriptor(8'h00, 8'hFF, 32'h0000_0000);
      add_descriptor(8'h14, LEAD_OUT, 32'h8000_0001);
      play_toc();
      wait_drain();
   endtask

   // A lead-out with no track before it changes nothing.
   task automatic test_lead_out_only();
      toc_image.delete();
      add_header(16'd10, 8'd1, 8'd99);
      add_descriptor(8'h10, LEAD_OUT, 32'h0000_5A5A);
      play_toc();
      wait_drain();
   endtask

   task automatic test_track_limits();
      logic [6:0] lim;
      for (int i = 0; i < 5; i++) begin
         case (i)
            0: lim = 7'd1;
            1: lim = 7'd0;
            2: lim = 7'd127;
            3: lim = 7'd2;
            default: lim = 7'd99;
         endcase
         write_track_limit(lim);
         // A write to an unused address must leave the limit alone.
         if (i == 3) write_csr(SPARE_ADDR, $urandom);
         run_responses(30);
         wait_drain();
      end
   endtask

   task automatic test_idling_mixes();
      for (int m = 0; m < 4; m++) begin
         case (m)
            0: set_idling(0, 0);
            1: set_idling(70, 0);
            2: set_idling(0, 70);
            default: set_idling(8, 8);
         endcase
         write_track_limit(($urandom_range(0, 2) == 0) ? 7'd99 : 7'($urandom_range(1, 99)));
         run_responses(70);
         wait_drain();
      end
      set_idling(0, 0);
   endtask

   // The result side holds off while bytes keep coming, so the input must stall.
   task automatic test_result_back_pressure();
      logic [31:0] lba;
      write_track_limit(7'd99);
      toc_image.delete();
      add_header(16'(2 + 8 * 17), 8'd1, 8'd16);
      lba = $urandom_range(0, 1000);
      for (int i = 1; i <= 16; i++) begin
         lba = lba + $urandom_range(1, 30000);
         add_descriptor(8'($urandom), 8'(i), lba);
      end
      add_descriptor(8'($urandom), LEAD_OUT, lba + 32'd4500);
      hold_off_cycles = 300;
      play_toc();
      wait_drain();
   endtask

   // Over a thousand bytes: the descriptor cap and position saturation both apply.
   task automatic test_long_response();
      logic [31:0] lba;
      write_track_limit(7'd127);
      toc_image.delete();
      add_header(16'hFFFF, 8'h00, 8'hFE);
      lba = $urandom_range(0, 1000);
      for (int i = 0; i < 128; i++) begin
         lba = lba + $urandom_range(1, 5000);
         add_descriptor(8'($urandom), 8'(i), lba);
      end
      play_toc();
      wait_drain();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_summary();
      test_field_extremes();
      test_lead_out_only();
      test_track_limits();
      test_idling_mixes();
      test_result_back_pressure();
      test_long_response();
      wait_drain();
      mismatch_count += track_entries_due.size();
      $display("Sent %0d bytes in %0d responses and checked %0d results.",
               bytes_sent, responses_sent, entries_checked);
      $display("Track limits 0 to 127, four idling mixes, a long stall, a saturating response.");
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ----- cd_toc_track_list_parser.f -----
rtl/core/ctlp_pkg.sv
rtl/core/ctlp_parser.sv
rtl/core/ctlp_rsp_fifo.sv
rtl/core/cd_toc_track_list_parser.sv
rtl/core/ctlp_checker.sv
bench/cd_toc_track_list_parser_test.sv
